// ----- rtl/ffv_pkg.sv -----
`default_nettype none
package ffv_pkg;
  localparam int InW = 24;
  localparam int OutW = 18;
  localparam int VecW = 49;
  localparam int MagW = 30;
  localparam int SqW = 62;
  localparam int RtW = 31;
  localparam int QW = 47;
  localparam logic [OutW-1:0] UnitOne = 18'd65536;
endpackage
`default_nettype wire

// ----- rtl/ffv_unitize.sv -----
`default_nettype none
// Pipelined normalizer: magnitude/shift, squares, sum, bitwise root, restoring divide.
module ffv_unitize #(
  parameter int VW = ffv_pkg::VecW
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic signed [VW-1:0] vx,
  input  wire logic signed [VW-1:0] vy,
  input  wire logic signed [VW-1:0] vz,
  output logic out_valid,
  output logic signed [ffv_pkg::OutW-1:0] ux,
  output logic signed [ffv_pkg::OutW-1:0] uy,
  output logic signed [ffv_pkg::OutW-1:0] uz,
  output logic zero
);
  localparam int MW = ffv_pkg::MagW;
  localparam int RW = ffv_pkg::RtW;
  localparam int SW = ffv_pkg::SqW + 2;
  localparam int QW = ffv_pkg::QW;
  localparam int NR = RW;
  localparam int ND = 18;
  localparam int DS = NR + ND + 3;

  logic [DS:0] vld;
  logic [2:0] sgn [DS+1];
  logic [MW-1:0] m [NR+3][3];
  logic [SW-1:0] sq [3];
  logic [SW-1:0] rem [NR+1];
  logic [SW-1:0] rt [NR+1];
  logic [QW+1:0] drem [ND+1][3];
  logic [17:0] q [ND+1][3];
  logic [RW-1:0] nd [ND+1];

  logic [VW-1:0] a0, a1, a2, mx;
  logic [VW-1:0] s0, s1, s2;
  always_comb begin
    a0 = vx[VW-1] ? VW'(-vx) : VW'(vx);
    a1 = vy[VW-1] ? VW'(-vy) : VW'(vy);
    a2 = vz[VW-1] ? VW'(-vz) : VW'(vz);
    mx = a0 | a1 | a2;
    s0 = a0; s1 = a1; s2 = a2;
    for (int s = 0; s < VW; s++) begin
      if ((mx >> s) < (VW'(1) << MW) && ((s == 0) || (mx >> (s - 1)) >= (VW'(1) << MW))) begin
        s0 = a0 >> s; s1 = a1 >> s; s2 = a2 >> s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[DS-1:0], in_valid};
    sgn[0] <= {vz[VW-1], vy[VW-1], vx[VW-1]};
    m[0][0] <= MW'(s0); m[0][1] <= MW'(s1); m[0][2] <= MW'(s2);
    for (int k = 0; k < 3; k++) sq[k] <= SW'(m[0][k]) * SW'(m[0][k]);
    sgn[1] <= sgn[0]; m[1] <= m[0];
    rem[0] <= sq[0] + sq[1] + sq[2];
    rt[0] <= '0;
    sgn[2] <= sgn[1]; m[2] <= m[1];
    for (int i = 0; i < NR; i++) begin
      logic [SW-1:0] b, t;
      b = SW'(1) << (2 * (NR - 1 - i));
      t = rt[i] + b;
      if (rem[i] >= t) begin
        rem[i+1] <= rem[i] - t;
        rt[i+1] <= (rt[i] >> 1) + b;
      end else begin
        rem[i+1] <= rem[i];
        rt[i+1] <= rt[i] >> 1;
      end
      sgn[i+3] <= sgn[i+2]; m[i+3] <= m[i+2];
    end
    nd[0] <= RW'(rt[NR]);
    for (int k = 0; k < 3; k++) begin
      drem[0][k] <= (QW+2)'({m[NR+2][k], 16'd0}) + (QW+2)'(rt[NR] >> 1);
      q[0][k] <= '0;
    end
    sgn[NR+3] <= sgn[NR+2];
    for (int i = 0; i < ND; i++) begin
      nd[i+1] <= nd[i];
      sgn[NR+4+i] <= sgn[NR+3+i];
      for (int k = 0; k < 3; k++) begin
        logic [QW+1:0] dd;
        dd = (QW+2)'(nd[i]) << (ND - 1 - i);
        if (q[i][k] >= 18'd65536) begin
          drem[i+1][k] <= drem[i][k];
          q[i+1][k] <= 18'd65536;
        end else if (drem[i][k] >= dd && (drem[i][k] >> (ND-1-i)) >= (QW+2)'(nd[i])) begin
          drem[i+1][k] <= drem[i][k] - dd;
          q[i+1][k] <= q[i][k] | (18'd1 << (ND - 1 - i));
        end else begin
          drem[i+1][k] <= drem[i][k];
          q[i+1][k] <= q[i][k];
        end
      end
    end
  end

  logic [17:0] qc [3];
  logic hi;
  always_comb begin
    hi = 1'b0;
    for (int k = 0; k < 3; k++) begin
      qc[k] = (q[ND][k] > ffv_pkg::UnitOne) ? ffv_pkg::UnitOne : q[ND][k];
      if (nd[ND] == '0) qc[k] = '0;
    end
    hi = (nd[ND] == '0);
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vld[DS];
    ux <= sgn[DS][0] ? -$signed(qc[0]) : $signed(qc[0]);
    uy <= sgn[DS][1] ? -$signed(qc[1]) : $signed(qc[1]);
    uz <= sgn[DS][2] ? -$signed(qc[2]) : $signed(qc[2]);
    zero <= hi;
  end
endmodule
`default_nettype wire

// ----- rtl/frenet_frame_from_two_vectors_unit.sv -----
`default_nettype none
// channel   signals                                   handshake
// input     first_*, second_* (24b Q11.12)            start & !busy
// result    tangent_*, binormal_*, normal_*, degenerate done strobe, one cycle
// One transaction enters per cycle; busy is tied low. done rises after the accepting
// edge once data passes a cross-product stage, a normalizer pass, a second cross-product
// stage and a second normalizer pass, each pass set by the bitwise root and divide stages.
// Reset (rst, synchronous) clears only valid bits. Results cannot be stalled.
module frenet_frame_from_two_vectors_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic signed [23:0] first_x,
  input  wire logic signed [23:0] first_y,
  input  wire logic signed [23:0] first_z,
  input  wire logic signed [23:0] second_x,
  input  wire logic signed [23:0] second_y,
  input  wire logic signed [23:0] second_z,
  output logic done,
  output logic signed [17:0] tangent_x,
  output logic signed [17:0] tangent_y,
  output logic signed [17:0] tangent_z,
  output logic signed [17:0] binormal_x,
  output logic signed [17:0] binormal_y,
  output logic signed [17:0] binormal_z,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [17:0] normal_z,
  output logic degenerate
);
  assign busy = 1'b0;
  logic v0, v1;
  logic signed [47:0] p [6];
  logic signed [24:0] md0 [3], md1 [3];
  logic signed [48:0] cx, cy, cz, mx, my, mz;
  always_ff @(posedge clk) begin
    if (rst) begin v0 <= 1'b0; v1 <= 1'b0; end
    else begin v0 <= start; v1 <= v0; end
    p[0] <= first_y * second_z; p[1] <= second_y * first_z;
    p[2] <= first_z * second_x; p[3] <= second_z * first_x;
    p[4] <= first_x * second_y; p[5] <= second_x * first_y;
    md0[0] <= 25'(first_x) + 25'(second_x);
    md0[1] <= 25'(first_y) + 25'(second_y);
    md0[2] <= 25'(first_z) + 25'(second_z);
    md1 <= md0;
    cx <= 49'(p[0]) - 49'(p[1]); cy <= 49'(p[2]) - 49'(p[3]);
    cz <= 49'(p[4]) - 49'(p[5]);
  end
  assign mx = 49'(md1[0]); assign my = 49'(md1[1]); assign mz = 49'(md1[2]);

  logic bv, tv, bz, tz;
  logic signed [17:0] bx, by, bzz, tx, ty, tzz;
  ffv_unitize #(.VW(ffv_pkg::VecW)) u_b (.clk, .rst, .in_valid(v1),
    .vx(cx), .vy(cy), .vz(cz), .out_valid(bv), .ux(bx), .uy(by), .uz(bzz), .zero(bz));
  ffv_unitize #(.VW(ffv_pkg::VecW)) u_t (.clk, .rst, .in_valid(v1),
    .vx(mx), .vy(my), .vz(mz), .out_valid(tv), .ux(tx), .uy(ty), .uz(tzz), .zero(tz));

  logic w0, w1;
  logic signed [35:0] r [6];
  logic signed [36:0] nx, ny, nz;
  logic signed [17:0] hb [2][3], ht [2][3];
  logic hd [2];
  always_ff @(posedge clk) begin
    if (rst) begin w0 <= 1'b0; w1 <= 1'b0; end
    else begin w0 <= bv; w1 <= w0; end
    r[0] <= by * tzz; r[1] <= ty * bzz; r[2] <= bzz * tx;
    r[3] <= tzz * bx; r[4] <= bx * ty; r[5] <= tx * by;
    hb[0] <= '{bx, by, bzz}; ht[0] <= '{tx, ty, tzz}; hd[0] <= bz | tz;
    hb[1] <= hb[0]; ht[1] <= ht[0]; hd[1] <= hd[0];
    nx <= 37'(r[0]) - 37'(r[1]); ny <= 37'(r[2]) - 37'(r[3]);
    nz <= 37'(r[4]) - 37'(r[5]);
  end

  logic signed [48:0] ex, ey, ez;
  assign ex = 49'(nx); assign ey = 49'(ny); assign ez = 49'(nz);
  logic nv, nzr;
  logic signed [17:0] ox, oy, oz;
  ffv_unitize #(.VW(ffv_pkg::VecW)) u_n (.clk, .rst, .in_valid(w1),
    .vx(ex), .vy(ey), .vz(ez), .out_valid(nv), .ux(ox), .uy(oy), .uz(oz), .zero(nzr));

  localparam int NL = 54;
  logic signed [17:0] db [NL][3], dt [NL][3];
  logic dd [NL];
  always_ff @(posedge clk) begin
    db[0] <= hb[1]; dt[0] <= ht[1]; dd[0] <= hd[1];
    for (int i = 1; i < NL; i++) begin
      db[i] <= db[i-1]; dt[i] <= dt[i-1]; dd[i] <= dd[i-1];
    end
  end
  assign done = nv;
  assign tangent_x = dt[NL-1][0]; assign tangent_y = dt[NL-1][1];
  assign tangent_z = dt[NL-1][2];
  assign binormal_x = db[NL-1][0]; assign binormal_y = db[NL-1][1];
  assign binormal_z = db[NL-1][2];
  assign normal_x = ox; assign normal_y = oy; assign normal_z = oz;
  assign degenerate = dd[NL-1] | nzr;

  a_sync: assert property (@(posedge clk) disable iff (rst) bv == tv)
    else $error("normalizer lanes out of step");
  a_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_deg: assert property (@(posedge clk) disable iff (rst)
    (done && normal_x == 18'sd0 && normal_y == 18'sd0 && normal_z == 18'sd0) |-> degenerate)
    else $error("zero normal without degenerate");
endmodule
`default_nettype wire

// ----- test/tb_frenet_frame_from_two_vectors_unit.sv -----
`timescale 1ns / 100ps
module tb_frenet_frame_from_two_vectors_unit;

  typedef struct {
    logic signed [ffv_pkg::OutW-1:0] t [3];
    logic signed [ffv_pkg::OutW-1:0] b [3];
    logic signed [ffv_pkg::OutW-1:0] n [3];
    logic                            degen;
  } frame_t;

  function automatic bit unit_vec(input longint v [3], output longint u [3]);
    longint unsigned m [3];
    longint unsigned mx, sum, rt, bitv, q;
    int s;
    s = 0;
    for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    while ((mx >> s) >= (64'd1 << ffv_pkg::MagW)) s++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> s;
      sum += m[i] * m[i];
    end
    rt = 0;
    bitv = 64'd1 << 62;
    while (bitv > sum) bitv >>= 2;
    while (bitv != 0) begin
      if (sum >= rt + bitv) begin
        sum -= rt + bitv;
        rt = (rt >> 1) + bitv;
      end else begin
        rt >>= 1;
      end
      bitv >>= 2;
    end
    if (rt == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 0;
    end
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 65536 + rt / 2) / rt;
      if (q > 65536) q = 65536;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic void cross3(input longint a [3], input longint b [3],
                                 output longint r [3]);
    r[0] = a[1] * b[2] - b[1] * a[2];
    r[1] = a[2] * b[0] - b[2] * a[0];
    r[2] = a[0] * b[1] - b[0] * a[1];
  endfunction

  function automatic frame_t frenet_frame(input logic signed [ffv_pkg::InW-1:0] va [3],
                                          input logic signed [ffv_pkg::InW-1:0] vb [3]);
    longint a [3], b [3], c [3], mid [3], bn [3], tn [3], nm [3];
    frame_t f;
    bit ok;
    for (int i = 0; i < 3; i++) begin
      a[i] = va[i];
      b[i] = vb[i];
      mid[i] = a[i] + b[i];
    end
    cross3(a, b, c);
    ok = unit_vec(c, bn);
    ok = unit_vec(mid, tn) & ok;
    cross3(bn, tn, c);
    ok = unit_vec(c, nm) & ok;
    for (int i = 0; i < 3; i++) begin
      f.t[i] = 18'(tn[i]);
      f.b[i] = 18'(bn[i]);
      f.n[i] = 18'(nm[i]);
    end
    f.degen = !ok;
    return f;
  endfunction

  class frame_scoreboard;
    frame_t pending [$];
    int errors = 0;

    function void note_input(logic signed [ffv_pkg::InW-1:0] va [3],
                             logic signed [ffv_pkg::InW-1:0] vb [3]);
      pending.push_back(frenet_frame(va, vb));
    endfunction

    function void check_result(frame_t got);
      frame_t e;
      bit bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t", $time);
        return;
      end
      e = pending.pop_front();
      bad = got.degen !== e.degen;
      for (int i = 0; i < 3; i++)
        if (got.t[i] !== e.t[i] || got.b[i] !== e.b[i] || got.n[i] !== e.n[i]) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t: exp t=%0d,%0d,%0d b=%0d,%0d,%0d n=%0d,%0d,%0d d=%0b",
                   $time, e.t[0], e.t[1], e.t[2], e.b[0], e.b[1], e.b[2],
                   e.n[0], e.n[1], e.n[2], e.degen);
          $display("  got t=%0d,%0d,%0d b=%0d,%0d,%0d n=%0d,%0d,%0d d=%0b",
                   got.t[0], got.t[1], got.t[2], got.b[0], got.b[1], got.b[2],
                   got.n[0], got.n[1], got.n[2], got.degen);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done, degenerate;
  logic signed [23:0] first_x = 0, first_y = 0, first_z = 0;
  logic signed [23:0] second_x = 0, second_y = 0, second_z = 0;
  logic signed [17:0] tangent_x, tangent_y, tangent_z;
  logic signed [17:0] binormal_x, binormal_y, binormal_z;
  logic signed [17:0] normal_x, normal_y, normal_z;

  frenet_frame_from_two_vectors_unit dut (.*);

  always #4 clk = ~clk;

  frame_scoreboard sb = new();
  int idle_pct = 0;

  always @(posedge clk) begin
    frame_t got;
    if (!rst && done) begin
      got.t[0] = tangent_x; got.t[1] = tangent_y; got.t[2] = tangent_z;
      got.b[0] = binormal_x; got.b[1] = binormal_y; got.b[2] = binormal_z;
      got.n[0] = normal_x; got.n[1] = normal_y; got.n[2] = normal_z;
      got.degen = degenerate;
      sb.check_result(got);
    end
  end

  task automatic send_vectors(input logic signed [23:0] a [3], input logic signed [23:0] b [3]);
    logic signed [23:0] va [3], vb [3];
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    first_x <= a[0]; first_y <= a[1]; first_z <= a[2];
    second_x <= b[0]; second_y <= b[1]; second_z <= b[2];
    start <= 1;
    va = a;
    vb = b;
    do @(posedge clk); while (busy);
    sb.note_input(va, vb);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 0;
    do @(negedge clk); while (sb.pending.size() != 0);
  endtask

  function automatic logic signed [23:0] pick_comp(input int mode);
    case (mode)
      0: return 24'sh7fffff;
      1: return -24'sh800000;
      2: return 0;
      3: return $signed(24'($urandom_range(255))) - 128;
      default: return 24'($urandom);
    endcase
  endfunction

  logic signed [23:0] dir_vals [6] = '{24'sh7fffff, -24'sh800000, 0, 1, -1, 24'sh001000};

  initial begin
    logic signed [23:0] a [3], b [3];
    int md;
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    for (int k = 0; k < 24; k++) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = dir_vals[(k + i) % 6];
        b[i] = dir_vals[(k * 5 + i * 2 + 1) % 6];
      end
      if (k == 0) begin a = '{0, 0, 0}; b = '{0, 0, 0}; end
      if (k == 1) begin a = '{24'sh1000, 0, 0}; b = '{24'sh2000, 0, 0}; end
      if (k == 2) begin a = '{24'sh1000, 5, 0}; b = '{-24'sh1000, -5, 0}; end
      if (k == 3) begin a = '{24'sh7fffff, 0, 0}; b = '{0, 24'sh7fffff, 0}; end
      if (k == 4) begin
        a = '{-24'sh800000, -24'sh800000, -24'sh800000};
        b = '{24'sh7fffff, -24'sh800000, 24'sh7fffff};
      end
      send_vectors(a, b);
    end
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = ph == 0 ? 30 : (ph == 1 ? 59 : 0);
      for (int k = 0; k < 670; k++) begin
        md = $urandom_range(9);
        for (int i = 0; i < 3; i++) begin
          a[i] = md < 2 ? pick_comp($urandom_range(4)) : pick_comp(md < 4 ? 3 : 4);
          b[i] = md < 2 ? pick_comp($urandom_range(4)) : pick_comp(md < 4 ? 3 : 4);
        end
        if (md == 9) b = a;
        if (k == 300) drain();
        send_vectors(a, b);
      end
    end
    drain();
    repeat (150) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule
